[hw/rtl/obj_face_index_parser_core_defines.svh]
// ----------------------------------------------------------------------------
// OBJ face index parser - assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef OBJ_FACE_INDEX_PARSER_CORE_DEFINES_SVH
`define OBJ_FACE_INDEX_PARSER_CORE_DEFINES_SVH

// Check a property at every edge outside reset.
`define OFIP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define OFIP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/ofip_pkg.sv]
// ----------------------------------------------------------------------------
// OBJ face index parser - package
// Widths, character codes, parse phases, status codes and the result word.
// ----------------------------------------------------------------------------
package ofip_pkg;

   localparam int INDEX_BITS = 24;
   localparam int ACCUM_BITS = 32;
   localparam int VCOUNT_W   = 24;
   localparam int VC_BITS    = (INDEX_BITS < VCOUNT_W) ? INDEX_BITS : VCOUNT_W;
   localparam int CMP_BITS   = (ACCUM_BITS > VC_BITS) ? ACCUM_BITS : VC_BITS;
   localparam int PROD_BITS  = ACCUM_BITS + 4;
   localparam int COUNT_W    = 8;

   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);

   typedef logic [ACCUM_BITS-1:0]   acc_type;
   typedef logic [PROD_BITS-1:0]    prod_type;
   typedef logic [CMP_BITS-1:0]     cmp_type;
   typedef logic [VC_BITS-1:0]      vc_type;
   typedef logic [VCOUNT_W-1:0]     vidx_type;
   typedef logic [COUNT_W-1:0]      count_type;
   typedef logic [RSP_PTR_BITS-1:0] rsp_ptr_type;
   typedef logic [RSP_CNT_BITS-1:0] rsp_cnt_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_V     = 8'h76;

   localparam count_type COUNT_MAX        = 8'hFF;
   localparam count_type MIN_FACE_INDICES = 8'd3;

   typedef enum logic [2:0] {
      PH_START     = 3'd0,
      PH_KEYWORD   = 3'd1,
      PH_GAP       = 3'd2,
      PH_TOKEN     = 3'd3,
      PH_SKIPSLASH = 3'd4,
      PH_DISCARD   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KW_NONE  = 2'd0,
      KW_F     = 2'd1,
      KW_V     = 2'd2,
      KW_OTHER = 2'd3
   } kw_type;

   // ST_OK also serves as "no error recorded yet".
   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_BLANK     = 4'd1,
      ST_OTHER     = 4'd2,
      ST_VERTEX    = 4'd3,
      ST_EMPTY     = 4'd4,
      ST_SLASH     = 4'd5,
      ST_INVALID   = 4'd6,
      ST_OVERFLOW  = 4'd7,
      ST_ZERO      = 4'd8,
      ST_RANGE     = 4'd9,
      ST_UNDER3    = 4'd10
   } status_type;

   typedef struct packed {
      logic       is_status;
      vidx_type   vertex_index;
      status_type line_status;
      count_type  index_count;
   } item_type;

   // Up to two result words produced by one input byte, first goes out first.
   typedef struct packed {
      logic [1:0] n;
      item_type   first;
      item_type   second;
   } push_type;

endpackage

[hw/rtl/obj_face_index_parser_core.sv]
// ----------------------------------------------------------------------------
// OBJ face index parser core
// Feed one OBJ text line, one byte per word on req_line_byte, a zero byte ending the
// line. Face lines ("f") yield one rsp word per vertex index (zero-based,
// negative indices resolved against vertex_count), and every line ends with
// one status word (rsp_is_status high) giving success or the first error and
// the number of indices sent. Indices of a failed line are to be dropped.
// csr_wr_en / csr_wr_data write vertex_count; write it only while idle.
// Path: a byte passes the input register, then the parser, into the result queue.
// Throughput: one byte per cycle while req_stall is low. A byte that ends a token
// at line end makes two rsp words, which leave by the single rsp port in turn;
// the 4-word result queue absorbs that, and req_stall rises only when the queue
// cannot take two more words.
// Stalling: rsp_stall holds the head word; the queue fills, then the input
// register holds its byte and req_stall stays high until space opens.
// Reset: synchronous, active high; clears the parser to line start, empties
// the queue and sets vertex_count to zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "obj_face_index_parser_core_defines.svh"

module obj_face_index_parser_core (
   input  logic                          clock,
   input  logic                          reset,
   // input byte channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_line_byte,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_is_status,
   output logic [ofip_pkg::VCOUNT_W-1:0] rsp_vertex_index,
   output logic [3:0]                    rsp_line_status,
   output logic [ofip_pkg::COUNT_W-1:0]  rsp_index_count,
   // vertex_count register
   input  logic                          csr_wr_en,
   input  logic [ofip_pkg::VCOUNT_W-1:0] csr_wr_data
);

   logic [7:0]                    byte_ff, byte_in;
   logic                          byte_vld_ff, byte_vld_in;
   logic [ofip_pkg::VCOUNT_W-1:0] vcount_ff, vcount_in;

   logic                          accept, consume, room2, pop;
   ofip_pkg::push_type            push;
   ofip_pkg::item_type            head;

   // Input register: drain into the parser whenever the queue has room for
   // the worst case of two words, refill in the same cycle.
   always_comb begin
      consume     = byte_vld_ff & room2;
      req_stall   = byte_vld_ff & ~room2;
      accept      = req_valid & ~req_stall;
      byte_vld_in = accept | (byte_vld_ff & ~consume);
      byte_in     = accept ? req_line_byte : byte_ff;
      vcount_in   = csr_wr_en ? csr_wr_data : vcount_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
         vcount_ff   <= '0;
      end else begin
         byte_vld_ff <= byte_vld_in;
         vcount_ff   <= vcount_in;
      end
   end

   // Classify the byte and produce up to two result words.
   ofip_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .en           (consume),
      .byte_in      (byte_ff),
      .vertex_count (vcount_ff),
      .push         (push)
   );

   // Hold results until the receiver takes them.
   ofip_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (rsp_valid),
      .room2     (room2)
   );

   always_comb begin
      pop              = rsp_valid & ~rsp_stall;
      rsp_is_status    = head.is_status;
      rsp_vertex_index = head.vertex_index;
      rsp_line_status  = head.line_status;
      rsp_index_count  = head.index_count;
   end

   `OFIP_ASSERT_NEXT(a_byte_held, byte_vld_ff && !consume, byte_vld_ff && $stable(byte_ff), "held input byte lost or changed")

endmodule

[hw/rtl/ofip_parse.sv]
// ----------------------------------------------------------------------------
// OBJ face index parser - line parser
// Per-byte phase update, decimal accumulate and index resolution.
// ----------------------------------------------------------------------------
`include "obj_face_index_parser_core_defines.svh"

module ofip_parse (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic [7:0]                           byte_in,
   input  logic [ofip_pkg::VCOUNT_W-1:0]        vertex_count,
   output ofip_pkg::push_type                   push
);

   ofip_pkg::phase_type  phase_ff, phase_in;
   ofip_pkg::kw_type     kw_ff, kw_in;
   ofip_pkg::acc_type    acc_ff, acc_in;
   logic                 ovf_ff, ovf_in;
   logic                 rel_ff, rel_in;
   logic                 dig_ff, dig_in;
   ofip_pkg::count_type  cnt_ff, cnt_in;
   ofip_pkg::status_type err_ff, err_in;

   logic                 is_nul, is_blank, is_slash, is_minus, is_hash, is_digit;
   logic [3:0]           digit;
   logic                 tok_fresh, tok_path, tok_end;
   ofip_pkg::acc_type    tok_acc;
   logic                 tok_ovf, tok_rel, tok_dig;
   ofip_pkg::prod_type   prod;
   logic                 prod_ovf;
   ofip_pkg::vc_type     vc_eff, idx_eff;
   ofip_pkg::status_type tok_code, fail_code, err_new, line_status;
   logic                 do_fail, emit;
   ofip_pkg::count_type  cnt_new;
   ofip_pkg::item_type   idx_item, stat_item;

   // Character classes.
   always_comb begin
      is_nul   = (byte_in == ofip_pkg::CH_NUL);
      is_blank = byte_in inside {ofip_pkg::CH_SPACE, ofip_pkg::CH_TAB};
      is_slash = (byte_in == ofip_pkg::CH_SLASH);
      is_minus = (byte_in == ofip_pkg::CH_MINUS);
      is_hash  = (byte_in == ofip_pkg::CH_HASH);
      is_digit = byte_in inside {[ofip_pkg::CH_0:ofip_pkg::CH_9]};
      digit    = byte_in[3:0];   // '0'..'9' sit at 0x30..0x39
   end

   // Token evaluation; a token opened in the gap starts from a clean slate.
   always_comb begin
      tok_fresh = (phase_ff == ofip_pkg::PH_GAP);
      tok_acc   = tok_fresh ? '0 : acc_ff;
      tok_ovf   = tok_fresh ? 1'b0 : ovf_ff;
      tok_rel   = tok_fresh ? 1'b0 : rel_ff;
      tok_dig   = tok_fresh ? 1'b0 : dig_ff;
      tok_path  = (phase_ff == ofip_pkg::PH_TOKEN) ||
                  (tok_fresh && !is_nul && !is_blank && !is_slash && !is_minus);
      tok_end   = tok_path && (is_nul || is_blank || is_slash);

      prod      = {1'b0, tok_acc, 3'b000} + {3'b000, tok_acc, 1'b0} +
                  ofip_pkg::prod_type'(digit);
      prod_ovf  = |prod[ofip_pkg::PROD_BITS-1:ofip_pkg::ACCUM_BITS];

      vc_eff    = vertex_count[ofip_pkg::VC_BITS-1:0];
      if (!tok_dig)
         tok_code = ofip_pkg::ST_INVALID;
      else if (tok_ovf)
         tok_code = ofip_pkg::ST_OVERFLOW;
      else if (tok_acc == '0)
         tok_code = ofip_pkg::ST_ZERO;
      else if (ofip_pkg::cmp_type'(tok_acc) > ofip_pkg::cmp_type'(vc_eff))
         tok_code = ofip_pkg::ST_RANGE;
      else
         tok_code = ofip_pkg::ST_OK;

      // Accumulator is at most vc_eff here, so the narrowing is safe.
      idx_eff = tok_rel ? (vc_eff - ofip_pkg::vc_type'(tok_acc))
                        : (ofip_pkg::vc_type'(tok_acc) - ofip_pkg::vc_type'(1));
      emit    = tok_end && (tok_code == ofip_pkg::ST_OK);
   end

   // Errors, index count and the end-of-line status.
   always_comb begin
      do_fail   = 1'b0;
      fail_code = ofip_pkg::ST_OK;
      if (tok_fresh && is_slash) begin
         do_fail   = 1'b1;
         fail_code = ofip_pkg::ST_SLASH;
      end else if (tok_end && (tok_code != ofip_pkg::ST_OK)) begin
         do_fail   = 1'b1;
         fail_code = tok_code;
      end else if (tok_path && !tok_end && !is_digit) begin
         do_fail   = 1'b1;
         fail_code = ofip_pkg::ST_INVALID;
      end

      err_new = (do_fail && (err_ff == ofip_pkg::ST_OK)) ? fail_code : err_ff;
      cnt_new = (emit && (cnt_ff != ofip_pkg::COUNT_MAX)) ?
                cnt_ff + ofip_pkg::count_type'(1) : cnt_ff;

      if (err_new != ofip_pkg::ST_OK)
         line_status = err_new;
      else begin
         case (kw_ff)
            ofip_pkg::KW_F: begin
               if (cnt_new == '0)
                  line_status = ofip_pkg::ST_EMPTY;
               else if (cnt_new < ofip_pkg::MIN_FACE_INDICES)
                  line_status = ofip_pkg::ST_UNDER3;
               else
                  line_status = ofip_pkg::ST_OK;
            end
            ofip_pkg::KW_V:     line_status = ofip_pkg::ST_VERTEX;
            ofip_pkg::KW_OTHER: line_status = ofip_pkg::ST_OTHER;
            default:            line_status = ofip_pkg::ST_BLANK;
         endcase
      end
   end

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      kw_in    = kw_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      rel_in   = rel_ff;
      dig_in   = dig_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      if (en) begin
         if (is_nul) begin
            phase_in = ofip_pkg::PH_START;
            kw_in    = ofip_pkg::KW_NONE;
            acc_in   = '0;
            ovf_in   = 1'b0;
            rel_in   = 1'b0;
            dig_in   = 1'b0;
            cnt_in   = '0;
            err_in   = ofip_pkg::ST_OK;
         end else begin
            cnt_in = cnt_new;
            err_in = err_new;
            case (phase_ff)
               ofip_pkg::PH_START: begin
                  if (is_hash) begin
                     kw_in    = ofip_pkg::KW_NONE;
                     phase_in = ofip_pkg::PH_DISCARD;
                  end else if (!is_blank) begin
                     kw_in    = (byte_in == ofip_pkg::CH_F) ? ofip_pkg::KW_F :
                                (byte_in == ofip_pkg::CH_V) ? ofip_pkg::KW_V :
                                                              ofip_pkg::KW_OTHER;
                     phase_in = ofip_pkg::PH_KEYWORD;
                  end
               end
               ofip_pkg::PH_KEYWORD: begin
                  if (is_blank)
                     phase_in = (kw_ff == ofip_pkg::KW_F) ? ofip_pkg::PH_GAP
                                                          : ofip_pkg::PH_DISCARD;
                  else
                     kw_in = ofip_pkg::KW_OTHER;
               end
               ofip_pkg::PH_GAP: begin
                  if (is_minus) begin
                     acc_in   = '0;
                     ovf_in   = 1'b0;
                     dig_in   = 1'b0;
                     rel_in   = 1'b1;
                     phase_in = ofip_pkg::PH_TOKEN;
                  end else if (tok_path)
                     phase_in = ofip_pkg::PH_TOKEN;
               end
               ofip_pkg::PH_TOKEN: begin
                  if (tok_end)
                     phase_in = is_slash ? ofip_pkg::PH_SKIPSLASH : ofip_pkg::PH_GAP;
               end
               ofip_pkg::PH_SKIPSLASH: begin
                  if (is_blank)
                     phase_in = ofip_pkg::PH_GAP;
               end
               default: begin
               end
            endcase

            // Digits and bad characters of a token.
            if (tok_path && !tok_end) begin
               rel_in = tok_rel;
               dig_in = tok_dig | is_digit;
               ovf_in = tok_ovf | (is_digit & prod_ovf);
               acc_in = (is_digit && !tok_ovf && !prod_ovf) ?
                        prod[ofip_pkg::ACCUM_BITS-1:0] : tok_acc;
            end

            if (do_fail)
               phase_in = ofip_pkg::PH_DISCARD;
         end
      end
   end

   // Result words.
   always_comb begin
      idx_item.is_status    = 1'b0;
      idx_item.vertex_index = ofip_pkg::vidx_type'(idx_eff);
      idx_item.line_status  = ofip_pkg::ST_OK;
      idx_item.index_count  = cnt_new;

      stat_item.is_status    = 1'b1;
      stat_item.vertex_index = '0;
      stat_item.line_status  = line_status;
      stat_item.index_count  = cnt_new;

      push.first  = stat_item;
      push.second = stat_item;
      push.n      = 2'd0;
      if (en) begin
         if (emit) begin
            push.first = idx_item;
            push.n     = is_nul ? 2'd2 : 2'd1;
         end else if (is_nul)
            push.n = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ofip_pkg::PH_START;
         kw_ff    <= ofip_pkg::KW_NONE;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         rel_ff   <= 1'b0;
         dig_ff   <= 1'b0;
         cnt_ff   <= '0;
         err_ff   <= ofip_pkg::ST_OK;
      end else begin
         phase_ff <= phase_in;
         kw_ff    <= kw_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         rel_ff   <= rel_in;
         dig_ff   <= dig_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
      end
   end

   `OFIP_ASSERT_NEXT(a_line_end_clears, en && is_nul, (phase_ff == ofip_pkg::PH_START) && (cnt_ff == '0) && (err_ff == ofip_pkg::ST_OK), "line end did not clear parse state")
   `OFIP_ASSERT(a_pair_order, (push.n == 2'd2) |-> (!push.first.is_status && push.second.is_status), "two-word push must be index then status")

endmodule

[hw/rtl/ofip_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// OBJ face index parser - result queue
// Small register queue taking up to two words a cycle, handing out one.
// ----------------------------------------------------------------------------
`include "obj_face_index_parser_core_defines.svh"

module ofip_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  ofip_pkg::push_type push,
   input  logic               pop,
   output ofip_pkg::item_type head,
   output logic               not_empty,
   output logic               room2
);

   ofip_pkg::item_type    mem_ff [ofip_pkg::RSP_DEPTH];
   ofip_pkg::rsp_ptr_type wr_ptr_ff, wr_ptr_in;
   ofip_pkg::rsp_ptr_type rd_ptr_ff, rd_ptr_in;
   ofip_pkg::rsp_cnt_type cnt_ff, cnt_in;
   ofip_pkg::rsp_ptr_type wr_ptr_nx;

   always_comb begin
      wr_ptr_nx = wr_ptr_ff + ofip_pkg::rsp_ptr_type'(1);
      wr_ptr_in = wr_ptr_ff + ofip_pkg::rsp_ptr_type'(push.n);
      rd_ptr_in = rd_ptr_ff + ofip_pkg::rsp_ptr_type'(pop);
      cnt_in    = cnt_ff + ofip_pkg::rsp_cnt_type'(push.n) -
                  ofip_pkg::rsp_cnt_type'(pop);
      not_empty = (cnt_ff != '0);
      room2     = (cnt_ff <= ofip_pkg::rsp_cnt_type'(ofip_pkg::RSP_DEPTH - 2));
      head      = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push.n != 2'd0)
         mem_ff[wr_ptr_ff] <= push.first;
      if (push.n == 2'd2)
         mem_ff[wr_ptr_nx] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   `OFIP_ASSERT(a_no_overfill, (push.n == 2'd2) |-> (cnt_ff <= ofip_pkg::RSP_DEPTH - 2), "result queue pushed past its depth")
   `OFIP_ASSERT(a_empty_ptrs, (cnt_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff), "empty queue with pointers apart")

endmodule
